// ===== hdl/round_robin_task_scheduler_macros.svh =====
// Assertion macros used by the scheduler datapath.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define RRTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in any cycle implies consequent in the next cycle.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rrts_pkg.sv =====
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

	// Width of the queue count on the result channel.
	localparam int COUNT_W = 5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // input transfer this cycle, capture the item
		logic rd_en;     // issue a read of the slot memories
		logic rd_chain;  // read address is the link just read
		logic link_wr;   // write the new task's link
		logic cur_load;  // latch the slot being served
		logic commit;    // apply all updates and load the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_tick;     // incoming item is a tick
		logic enq_bad;     // incoming enqueue would be rejected
		logic count_zero;  // queue is empty
		logic out_free;    // result register can take a new result
	} status_t;

endpackage

// ===== hdl/rrts_ctrl.sv =====
// Controller state machine of the round-robin task scheduler.
module rrts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rrts_pkg::status_t status,
	output rrts_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LINK  = 4'b0010,
		S_CHAIN = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					cmd.rd_en  = 1'b1;
					if (status.count_zero || (!status.in_tick && status.enq_bad)) begin
						state_d = S_FIN;
					end else if (status.in_tick) begin
						state_d = S_CHAIN;
					end else begin
						state_d = S_LINK;
					end
				end
			end
			S_LINK: begin
				cmd.link_wr = 1'b1;
				state_d     = S_FIN;
			end
			S_CHAIN: begin
				cmd.cur_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_chain = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rrts_dp.sv =====
// Datapath of the round-robin task scheduler: slot memories, pointers and result register.
`include "round_robin_task_scheduler_macros.svh"

module rrts_dp #(
	parameter int MAX_TASKS     = 16,
	parameter int DURATION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rrts_pkg::cmd_t                 cmd,
	output rrts_pkg::status_t              status,
	input  logic                           kind,
	input  logic [3:0]                     task_id,
	input  logic [15:0]                    duration,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [3:0]                     served_task,
	output logic                           idle,
	output logic                           completed,
	output logic                           rejected,
	output logic [rrts_pkg::COUNT_W-1:0]   queue_count
);

	localparam int SLOT_W = $clog2(MAX_TASKS);
	localparam int CW     = rrts_pkg::COUNT_W;
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	// Slot memories.
	logic [SLOT_W-1:0]        nl_mem [MAX_TASKS];
	logic [DURATION_BITS-1:0] rem_mem [MAX_TASKS];
	logic [SLOT_W-1:0]        nl_rd_q;
	logic [DURATION_BITS-1:0] rem_rd_q;

	// Queue state.
	logic [MAX_TASKS-1:0] occupied_q;
	logic [SLOT_W-1:0]    tail_q, cursor_q, cur_q;
	logic [CW-1:0]        count_q;

	// Captured item.
	logic                     kind_q, rej_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [DURATION_BITS-1:0] dur_q;

	// Result register.
	logic          out_valid_q;
	logic [3:0]    served_q;
	logic          idle_q, completed_q, rejected_q;
	logic [CW-1:0] qcount_q;

	logic [SLOT_W-1:0] in_slot, rd_addr;
	logic              id_ok, count_zero, done, enq_ok, tick_run, unlink;
	logic              nl_we, rem_we;
	logic [SLOT_W-1:0] nl_waddr, nl_wdata, rem_waddr;
	logic [DURATION_BITS-1:0] rem_wdata;
	logic [CW-1:0]     count_d;

	assign in_slot    = SLOT_W'(task_id);
	assign id_ok      = (32'(task_id) < MAX_TASKS);
	assign count_zero = (count_q == '0);

	assign status.in_tick    = kind;
	assign status.enq_bad    = !id_ok || occupied_q[in_slot];
	assign status.count_zero = count_zero;
	assign status.out_free   = !out_valid_q || out_ready;

	// Item decisions taken at commit.
	assign done     = (rem_rd_q <= DURATION_BITS'(1));
	assign enq_ok   = !kind_q && !rej_q;
	assign tick_run = kind_q && !count_zero;
	assign unlink   = tick_run && done && (count_q > CNT_ONE);

	always_comb begin
		if (cmd.rd_chain) begin
			rd_addr = nl_rd_q;
		end else if (kind) begin
			rd_addr = cursor_q;
		end else begin
			rd_addr = tail_q;
		end
	end

	// Link memory has one write port, shared by the link step and the commit.
	always_comb begin
		nl_we    = 1'b0;
		nl_waddr = slot_q;
		nl_wdata = nl_rd_q;
		if (cmd.link_wr) begin
			nl_we = 1'b1;
		end else if (cmd.commit && enq_ok) begin
			nl_we    = 1'b1;
			nl_waddr = count_zero ? slot_q : tail_q;
			nl_wdata = slot_q;
		end else if (cmd.commit && unlink) begin
			nl_we    = 1'b1;
			nl_waddr = cursor_q;
			nl_wdata = nl_rd_q;
		end
	end

	always_comb begin
		rem_we    = 1'b0;
		rem_waddr = slot_q;
		rem_wdata = dur_q;
		if (cmd.commit && enq_ok) begin
			rem_we = 1'b1;
		end else if (cmd.commit && tick_run && !done) begin
			rem_we    = 1'b1;
			rem_waddr = cur_q;
			rem_wdata = rem_rd_q - DURATION_BITS'(1);
		end
	end

	always_comb begin
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + CNT_ONE;
		end else if (tick_run && done) begin
			count_d = count_q - CNT_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (nl_we) begin
			nl_mem[nl_waddr] <= nl_wdata;
		end
		if (rem_we) begin
			rem_mem[rem_waddr] <= rem_wdata;
		end
		if (cmd.rd_en) begin
			nl_rd_q  <= nl_mem[rd_addr];
			rem_rd_q <= rem_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			slot_q <= in_slot;
			dur_q  <= DURATION_BITS'(duration);
			rej_q  <= status.enq_bad;
		end
		if (cmd.cur_load) begin
			cur_q <= nl_rd_q;
		end
		if (cmd.commit) begin
			served_q    <= tick_run ? 4'(cur_q) : 4'd0;
			idle_q      <= kind_q && count_zero;
			completed_q <= tick_run && done;
			rejected_q  <= !kind_q && rej_q;
			qcount_q    <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q  <= '0;
			tail_q      <= '0;
			cursor_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				count_q     <= count_d;
				if (enq_ok) begin
					occupied_q[slot_q] <= 1'b1;
					tail_q             <= slot_q;
					if (count_zero) begin
						cursor_q <= slot_q;
					end
				end else if (tick_run) begin
					if (done) begin
						occupied_q[cur_q] <= 1'b0;
					end
					if (unlink) begin
						if (tail_q == cur_q) begin
							tail_q <= cursor_q;
						end
					end else begin
						cursor_q <= cur_q;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign served_task = served_q;
	assign idle        = idle_q;
	assign completed   = completed_q;
	assign rejected    = rejected_q;
	assign queue_count = qcount_q;

	`RRTS_ASSERT(a_count_matches, $countones(occupied_q) == int'(count_q), "count out of step with occupancy")
	`RRTS_ASSERT(a_ptrs_occupied, count_zero || (occupied_q[cursor_q] && occupied_q[tail_q]), "cursor or tail on a free slot")
	`RRTS_ASSERT(a_commit_free, !cmd.commit || !out_valid_q || out_ready, "result overwritten before transfer")
	`RRTS_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid_q, "commit without a result")

endmodule

// ===== hdl/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler: controller plus datapath.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+---------------------------------------------------
//  input   | in_valid / in_ready | kind, task_id, duration
//  result  | out_valid/out_ready | served_task, idle, completed, rejected, queue_count
//
// One item is in work at a time. A tick on a non-empty queue and an enqueue that links
// behind an existing tail pass through a further state for the registered link memory
// read or link write; a rejected enqueue, an enqueue into an empty queue and an idle tick do not.
// Reset clears the occupancy flops, pointers, count and result valid; the slot memories
// need no clearing, since data read from a slot is used only while that slot is occupied.
// A finished result waits until the result register is free, and input waits with it.
module round_robin_task_scheduler #(
	parameter int MAX_TASKS     = 16,
	parameter int DURATION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [3:0]                   task_id,
	input  logic [15:0]                  duration,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [3:0]                   served_task,
	output logic                         idle,
	output logic                         completed,
	output logic                         rejected,
	output logic [rrts_pkg::COUNT_W-1:0] queue_count
);

	// Command and status groups between the controller and the datapath.
	rrts_pkg::cmd_t    cmd;
	rrts_pkg::status_t status;

	// The controller sequences each item through its read, link and commit steps.
	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the slots, the circular order and the result register.
	rrts_dp #(
		.MAX_TASKS     (MAX_TASKS),
		.DURATION_BITS (DURATION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.kind        (kind),
		.task_id     (task_id),
		.duration    (duration),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.served_task (served_task),
		.idle        (idle),
		.completed   (completed),
		.rejected    (rejected),
		.queue_count (queue_count)
	);

endmodule
